// ===== hdl/rcd_pkg.sv =====
`default_nettype none
package rcd_pkg;

  localparam int unsigned HDR_BITS   = 56;
  localparam int unsigned CS_BITS    = 24;
  localparam int unsigned CTL_BITS   = 32;
  localparam int unsigned PHASE_BITS = 4;

  localparam logic [PHASE_BITS-1:0] PH_BASIC   = 4'd0;
  localparam logic [PHASE_BITS-1:0] PH_FMT0    = 4'd11;
  localparam logic [PHASE_BITS-1:0] PH_FMT1    = 4'd7;
  localparam logic [PHASE_BITS-1:0] PH_FMT2    = 4'd3;
  localparam logic [PHASE_BITS-1:0] PH_MSID    = 4'd4;
  localparam logic [PHASE_BITS-1:0] PH_PAYLOAD = 4'd12;

  localparam logic [1:0] FMT_FULL  = 2'd0;
  localparam logic [1:0] FMT_NOSID = 2'd1;
  localparam logic [1:0] FMT_TS    = 2'd2;
  localparam logic [1:0] FMT_CONT  = 2'd3;

  localparam logic [7:0] MSG_SET_CHUNK = 8'd1;
  localparam logic [7:0] MSG_ACK_WIN   = 8'd5;
  localparam logic [7:0] MSG_PEER_BW   = 8'd6;

  localparam logic [CS_BITS-1:0] CS_RESET = 24'd128;
  localparam logic [CS_BITS-1:0] CS_MAX   = 24'hFFFFFF;

  localparam logic [1:0] REG_INIT_CS = 2'd0;

  typedef struct packed {
    logic               wr;
    logic [CS_BITS-1:0] value;
  } rcd_cfg_t;

endpackage
`default_nettype wire

// ===== hdl/rcd_if.sv =====
`default_nettype none
interface rcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

interface rcd_out_if;
  logic        valid;
  logic        ready;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic [5:0]  chunk_stream;
  logic [7:0]  msg_type;
  logic [23:0] message_length;
  logic [23:0] timestamp;
  logic        last_of_message;
  logic        control_error;
  logic        chunk_size_changed;
  modport source (output valid, output payload_valid, output payload_byte,
    output chunk_stream, output msg_type, output message_length,
    output timestamp, output last_of_message, output control_error,
    output chunk_size_changed, input ready);
  modport sink (input valid, input payload_valid, input payload_byte,
    input chunk_stream, input msg_type, input message_length,
    input timestamp, input last_of_message, input control_error,
    input chunk_size_changed, output ready);
endinterface
`default_nettype wire

// ===== hdl/rtmp_chunk_deframer.sv =====
`default_nettype none
// channel   dir  beat
// in_ch     in   one raw byte of the chunk stream
// out_ch    out  one payload byte or empty message notice, with header tags
// apb       in   initial_chunk_size at address 0
//
// one byte a cycle sustained unless a stalled result register holds the update stage; a byte passes the table read
// stage and then the update stage, which sets the per-stream loop
// the per-stream tables sit in a one-port-read, one-port-write memory
// reset is synchronous; no clearing pass, table entries carry valid bits
// a stalled result register holds the update stage, which then holds input
module rtmp_chunk_deframer
  import rcd_pkg::*;
#(
  parameter int unsigned STREAM_COUNT = 64,
  parameter int unsigned LENGTH_BITS  = 24
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  rcd_in_if.sink           in_ch,
  rcd_out_if.source        out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  rcd_cfg_t cfg;

  rcd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rcd_core #(.STREAM_COUNT(STREAM_COUNT), .LENGTH_BITS(LENGTH_BITS)) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );
endmodule
`default_nettype wire

// ===== hdl/rcd_cfg.sv =====
`default_nettype none
module rcd_cfg
  import rcd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output rcd_cfg_t         cfg
);
  logic [CS_BITS-1:0] init_cs_r;
  logic               wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && (paddr == REG_INIT_CS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_cs_r <= CS_RESET;
    end else if (wr) begin
      init_cs_r <= pwdata[CS_BITS-1:0];
    end
  end

  assign prdata    = (paddr == REG_INIT_CS) ? {8'd0, init_cs_r} : 32'd0;
  assign cfg.wr    = wr;
  assign cfg.value = pwdata[CS_BITS-1:0];
endmodule
`default_nettype wire

// ===== hdl/rcd_table.sv =====
`default_nettype none
module rcd_table
  import rcd_pkg::*;
#(
  parameter int unsigned STREAM_COUNT = 64,
  parameter int unsigned LENGTH_BITS  = 24,
  localparam int unsigned SLOT_BITS = (STREAM_COUNT > 1) ? $clog2(STREAM_COUNT) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   re,
  input  wire logic [SLOT_BITS-1:0]   raddr,
  output logic [HDR_BITS-1:0]         rd_hdr,
  output logic [LENGTH_BITS-1:0]      rd_prog,
  input  wire logic                   we,
  input  wire logic [SLOT_BITS-1:0]   waddr,
  input  wire logic [HDR_BITS-1:0]    wr_hdr,
  input  wire logic [LENGTH_BITS-1:0] wr_prog
);
  logic [HDR_BITS-1:0]    hdr_mem [STREAM_COUNT];
  logic [LENGTH_BITS-1:0] prog_mem [STREAM_COUNT];
  logic [STREAM_COUNT-1:0] vld_r;
  logic [HDR_BITS-1:0]    hdr_q_r;
  logic [LENGTH_BITS-1:0] prog_q_r;
  logic                   vld_q_r;

  always_ff @(posedge clk) begin
    if (we) begin
      hdr_mem[waddr]  <= wr_hdr;
      prog_mem[waddr] <= wr_prog;
    end
    if (re) begin
      hdr_q_r  <= hdr_mem[raddr];
      prog_q_r <= prog_mem[raddr];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_q_r <= 1'b0;
    end else begin
      if (we) vld_r[waddr] <= 1'b1;
      if (re) vld_q_r <= vld_r[raddr];
    end
  end

  assign rd_hdr  = vld_q_r ? hdr_q_r : '0;
  assign rd_prog = vld_q_r ? prog_q_r : '0;
endmodule
`default_nettype wire

// ===== hdl/rcd_core.sv =====
`default_nettype none
module rcd_core
  import rcd_pkg::*;
#(
  parameter int unsigned STREAM_COUNT = 64,
  parameter int unsigned LENGTH_BITS  = 24,
  localparam int unsigned SLOT_BITS = (STREAM_COUNT > 1) ? $clog2(STREAM_COUNT) : 1
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire rcd_cfg_t cfg,
  rcd_in_if.sink        in_ch,
  rcd_out_if.source     out_ch
);
  // stage 1: byte taken, table read at the slot its low bits would name
  logic                   in_acc;
  logic                   s2_v_r;
  logic [7:0]             s2_byte_r;
  logic [SLOT_BITS-1:0]   raddr;
  logic [HDR_BITS-1:0]    rd_hdr;
  logic [LENGTH_BITS-1:0] rd_prog;

  // working copy of the current stream's entry
  logic [PHASE_BITS-1:0]  phase_r, phase_nxt;
  logic [1:0]             fmt_r, fmt_nxt;
  logic [5:0]             stream_r, stream_nxt;
  logic [HDR_BITS-1:0]    hs_r, hs_nxt;
  logic [CS_BITS-1:0]     cbl_r, cbl_nxt;
  logic [CS_BITS-1:0]     csn_r, csn_nxt;
  logic [CTL_BITS-1:0]    ctl_r, ctl_nxt;
  logic [HDR_BITS-1:0]    hdr_r, hdr_nxt;
  logic [LENGTH_BITS-1:0] prog_r, prog_nxt;

  logic                   res_v;
  logic                   r_pv, r_last, r_err, r_chg;
  logic [7:0]             r_byte;
  logic                   s2_fire;
  logic                   out_free;

  logic                   ov_r;
  logic                   o_pv_r, o_last_r, o_err_r, o_chg_r;
  logic [7:0]             o_byte_r, o_type_r;
  logic [5:0]             o_stream_r;
  logic [23:0]            o_len_r, o_ts_r;

  function automatic logic [SLOT_BITS-1:0] slot_of(input logic [5:0] id);
    if ({1'b0, id} < 7'(STREAM_COUNT)) slot_of = id[SLOT_BITS-1:0];
    else slot_of = SLOT_BITS'(STREAM_COUNT - 1);
  endfunction

  assign out_free    = !ov_r || out_ch.ready;
  assign s2_fire     = s2_v_r && (!res_v || out_free);
  assign in_ch.ready = !s2_v_r || s2_fire;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign raddr       = slot_of(in_ch.stream_byte[5:0]);

  rcd_table #(.STREAM_COUNT(STREAM_COUNT), .LENGTH_BITS(LENGTH_BITS)) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .re      (in_acc),
    .raddr   (raddr),
    .rd_hdr  (rd_hdr),
    .rd_prog (rd_prog),
    .we      (s2_fire),
    .waddr   (slot_of(stream_nxt)),
    .wr_hdr  (hdr_nxt),
    .wr_prog (prog_nxt)
  );

  always_comb begin
    logic [HDR_BITS-1:0]    ent;
    logic [LENGTH_BITS-1:0] pr;
    logic [LENGTH_BITS-1:0] len;
    logic [LENGTH_BITS:0]   p1;
    logic                   do_begin;
    logic                   do_finish;
    logic [CS_BITS-1:0]     cs;
    logic [CS_BITS-1:0]     rem;
    logic [30:0]            v;
    phase_nxt  = phase_r;
    fmt_nxt    = fmt_r;
    stream_nxt = stream_r;
    hs_nxt     = hs_r;
    cbl_nxt    = cbl_r;
    csn_nxt    = csn_r;
    ctl_nxt    = ctl_r;
    hdr_nxt    = hdr_r;
    prog_nxt   = prog_r;
    res_v      = 1'b0;
    r_pv       = 1'b0;
    r_byte     = 8'd0;
    r_last     = 1'b0;
    r_err      = 1'b0;
    r_chg      = 1'b0;
    ent        = hdr_r;
    pr         = prog_r;
    do_begin   = 1'b0;
    do_finish  = 1'b0;
    len        = '0;
    p1         = '0;
    cs         = '0;
    rem        = '0;
    v          = '0;

    if (phase_r == PH_BASIC) begin
      fmt_nxt    = s2_byte_r[7:6];
      stream_nxt = s2_byte_r[5:0];
      hs_nxt     = '0;
      // same slot as the working copy: the copy is newer than the table
      if (slot_of(s2_byte_r[5:0]) != slot_of(stream_r)) begin
        ent = rd_hdr;
        pr  = rd_prog;
      end
      hdr_nxt  = ent;
      prog_nxt = pr;
      unique case (s2_byte_r[7:6])
        FMT_FULL:  phase_nxt = PH_FMT0;
        FMT_NOSID: phase_nxt = PH_FMT1;
        FMT_TS:    phase_nxt = PH_FMT2;
        default:   do_begin  = 1'b1;
      endcase
    end else if (phase_r <= PH_FMT0) begin
      // message stream id bytes of a full header are dropped
      if (fmt_r != FMT_FULL || phase_r > PH_MSID) hs_nxt = {hs_r[HDR_BITS-9:0], s2_byte_r};
      phase_nxt = phase_r - 4'd1;
      if (phase_nxt == PH_BASIC) begin
        if (fmt_r == FMT_TS) ent = {hs_nxt[23:0], hdr_r[31:0]};
        else ent = hs_nxt;
        hdr_nxt  = ent;
        do_begin = 1'b1;
      end
    end else if (phase_r == PH_PAYLOAD) begin
      res_v   = 1'b1;
      r_pv    = 1'b1;
      r_byte  = s2_byte_r;
      len     = hdr_r[8 +: LENGTH_BITS];
      p1      = {1'b0, prog_r} + 1'b1;
      ctl_nxt = {ctl_r[23:0], s2_byte_r};
      if (cbl_r != '0) cbl_nxt = cbl_r - 1'b1;
      if (p1 >= {1'b0, len}) begin
        prog_nxt  = '0;
        phase_nxt = PH_BASIC;
        cbl_nxt   = '0;
        do_finish = 1'b1;
      end else begin
        prog_nxt = p1[LENGTH_BITS-1:0];
        if (cbl_nxt == '0) phase_nxt = PH_BASIC;
      end
    end else begin
      phase_nxt = PH_BASIC;
    end

    if (do_begin) begin
      len = ent[8 +: LENGTH_BITS];
      if (fmt_nxt != FMT_CONT || pr >= len) pr = '0;
      prog_nxt = pr;
      if (pr == '0) ctl_nxt = '0;
      if (len == '0) begin
        phase_nxt = PH_BASIC;
        res_v     = 1'b1;
        do_finish = 1'b1;
      end else begin
        cs        = (csn_r == '0) ? CS_BITS'(1) : csn_r;
        rem       = CS_BITS'(len - pr);
        cbl_nxt   = (rem < cs) ? rem : cs;
        phase_nxt = PH_PAYLOAD;
      end
    end

    if (do_finish) begin
      r_last = 1'b1;
      v      = ctl_nxt[30:0];
      unique case (hdr_nxt[7:0])
        MSG_SET_CHUNK: begin
          if (len != LENGTH_BITS'(4) || v == '0) begin
            r_err = 1'b1;
          end else begin
            csn_nxt = (v[30:24] != '0) ? CS_MAX : v[23:0];
            r_chg   = 1'b1;
          end
        end
        MSG_ACK_WIN: r_err = (len != LENGTH_BITS'(4));
        MSG_PEER_BW: r_err = (len != LENGTH_BITS'(5));
        default:     r_err = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r   <= 1'b0;
      phase_r  <= PH_BASIC;
      fmt_r    <= FMT_FULL;
      stream_r <= '0;
      hs_r     <= '0;
      cbl_r    <= '0;
      csn_r    <= CS_RESET;
      ctl_r    <= '0;
      hdr_r    <= '0;
      prog_r   <= '0;
      ov_r     <= 1'b0;
    end else begin
      if (in_acc) s2_v_r <= 1'b1;
      else if (s2_fire) s2_v_r <= 1'b0;
      if (s2_fire) begin
        phase_r  <= phase_nxt;
        fmt_r    <= fmt_nxt;
        stream_r <= stream_nxt;
        hs_r     <= hs_nxt;
        cbl_r    <= cbl_nxt;
        csn_r    <= csn_nxt;
        ctl_r    <= ctl_nxt;
        hdr_r    <= hdr_nxt;
        prog_r   <= prog_nxt;
      end
      if (cfg.wr) csn_r <= cfg.value;
      if (s2_fire && res_v) ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) s2_byte_r <= in_ch.stream_byte;
    if (s2_fire && res_v) begin
      o_pv_r     <= r_pv;
      o_byte_r   <= r_byte;
      o_stream_r <= stream_nxt;
      o_type_r   <= hdr_nxt[7:0];
      o_len_r    <= 24'(hdr_nxt[8 +: LENGTH_BITS]);
      o_ts_r     <= hdr_nxt[55:32];
      o_last_r   <= r_last;
      o_err_r    <= r_err;
      o_chg_r    <= r_chg;
    end
  end

  assign out_ch.valid              = ov_r;
  assign out_ch.payload_valid      = o_pv_r;
  assign out_ch.payload_byte       = o_byte_r;
  assign out_ch.chunk_stream       = o_stream_r;
  assign out_ch.msg_type           = o_type_r;
  assign out_ch.message_length     = o_len_r;
  assign out_ch.timestamp          = o_ts_r;
  assign out_ch.last_of_message    = o_last_r;
  assign out_ch.control_error      = o_err_r;
  assign out_ch.chunk_size_changed = o_chg_r;
endmodule
`default_nettype wire
